// ----- rtl/core/patm_pkg.sv -----
`default_nettype none

// Shared types and sizes for the point-update max tree.
package patm_pkg;

    // The table size follows from the slot width, so the tree is always complete.
    localparam int SLOT_W      = 10;
    localparam int VAL_W       = 32;
    localparam int LEAVES      = 1 << SLOT_W;
    localparam int INNER_DEPTH = LEAVES - 1;

    typedef logic [SLOT_W-1:0]       slot_t;
    typedef logic signed [VAL_W-1:0] val_t;

    // One request: which counter to change and by how much.
    typedef struct packed {
        slot_t slot;
        val_t  delta;
    } req_t;

    // One result: the global maximum and the lowest slot that holds it.
    typedef struct packed {
        val_t  best_value;
        slot_t best_slot;
    } rsp_t;

    // A tree entry: the best value of a range and where it lies.
    typedef struct packed {
        val_t  value;
        slot_t slot;
    } entry_t;

    // Memory command from the sequencer to the storage.
    typedef struct packed {
        logic   leaf_we;
        slot_t  leaf_waddr;
        val_t   leaf_wdata;
        slot_t  leaf_raddr;
        logic   inner_we;
        slot_t  inner_waddr;
        entry_t inner_wdata;
        slot_t  inner_raddr;
    } mem_cmd_t;

endpackage

`default_nettype wire

// ----- rtl/core/patm_mem.sv -----
`default_nettype none

// Leaf counters and inner tree nodes, each one write and one read per cycle.
// Inner node storage is in-order: the node splitting at m lives at index m.
module patm_mem (
    input  wire logic               clk,
    input  wire patm_pkg::mem_cmd_t cmd,
    output patm_pkg::val_t          leaf_rdata,
    output patm_pkg::entry_t        inner_rdata
);

    patm_pkg::val_t   leaf_mem  [0:patm_pkg::LEAVES-1];
    patm_pkg::entry_t inner_mem [0:patm_pkg::INNER_DEPTH-1];

    patm_pkg::val_t   leaf_rdata_reg;
    patm_pkg::entry_t inner_rdata_reg;

    // Leaf counter memory with registered read data.
    always_ff @(posedge clk)
    begin
        if (cmd.leaf_we)
        begin
            leaf_mem[cmd.leaf_waddr] <= cmd.leaf_wdata;
        end
        leaf_rdata_reg <= leaf_mem[cmd.leaf_raddr];
    end

    // Inner node memory with registered read data.
    always_ff @(posedge clk)
    begin
        if (cmd.inner_we)
        begin
            inner_mem[cmd.inner_waddr] <= cmd.inner_wdata;
        end
        inner_rdata_reg <= inner_mem[cmd.inner_raddr];
    end

    assign leaf_rdata  = leaf_rdata_reg;
    assign inner_rdata = inner_rdata_reg;

endmodule

`default_nettype wire

// ----- rtl/core/patm_pick.sv -----
`default_nettype none

// Shared compare and select unit: keeps the larger child, the left one on a tie.
module patm_pick (
    input  wire patm_pkg::entry_t cur,
    input  wire patm_pkg::entry_t sib,
    input  wire logic             cur_is_right,
    output patm_pkg::entry_t      win
);

    patm_pkg::entry_t left_child;
    patm_pkg::entry_t right_child;

    // Put the two children back in slot order before comparing.
    always_comb
    begin
        left_child  = cur_is_right ? sib : cur;
        right_child = cur_is_right ? cur : sib;
        if ($signed(left_child.value) >= $signed(right_child.value))
        begin
            win = left_child;
        end
        else
        begin
            win = right_child;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/patm_ctrl.sv -----
`default_nettype none

// Sequencer: clears the memories after reset, then for each request updates
// one leaf and walks the path to the root, one tree level per cycle.
module patm_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire patm_pkg::req_t   req,
    output logic                  busy,
    output logic                  done,
    output patm_pkg::rsp_t        rsp,
    input  wire patm_pkg::val_t   leaf_rdata,
    input  wire patm_pkg::entry_t inner_rdata,
    input  wire patm_pkg::entry_t win,
    output patm_pkg::entry_t      cur,
    output patm_pkg::entry_t      sib,
    output logic                  cur_is_right,
    output patm_pkg::mem_cmd_t    cmd
);

    typedef enum logic [3:0] {
        ST_CLEAR = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_ADD   = 4'b0100,
        ST_CMP   = 4'b1000
    } state_t;

    state_t           state_reg, state_next;
    patm_pkg::slot_t  clr_reg, clr_next;
    logic             done_reg, done_next;
    patm_pkg::rsp_t   rsp_reg, rsp_next;
    patm_pkg::slot_t  slot_reg, slot_next;
    patm_pkg::val_t   delta_reg, delta_next;
    patm_pkg::slot_t  idx_reg, idx_next;
    patm_pkg::slot_t  bit_reg, bit_next;
    patm_pkg::slot_t  half_reg, half_next;
    patm_pkg::entry_t cur_reg, cur_next;

    patm_pkg::val_t   sum;
    patm_pkg::slot_t  node_idx;
    patm_pkg::slot_t  bit_up;

    // Path arithmetic. idx_reg is the child just updated, bit_reg marks the
    // level being rebuilt and half_reg the level below it, so the parent is
    // the child with its lower bits filled and the level bit cleared.
    always_comb
    begin
        sum          = leaf_rdata + delta_reg;
        node_idx     = (idx_reg | half_reg) & ~bit_reg;
        bit_up       = {bit_reg[patm_pkg::SLOT_W-2:0], 1'b0};
        cur_is_right = |(idx_reg & bit_reg);
        cur          = cur_reg;
        if (bit_reg[0])
        begin
            sib.value = leaf_rdata;
            sib.slot  = idx_reg ^ bit_reg;
        end
        else
        begin
            sib = inner_rdata;
        end
    end

    // Memory commands. Reads are issued every cycle, in the cycle before their data is used:
    // the requested leaf when idle, the next sibling while walking up.
    always_comb
    begin
        cmd             = '0;
        cmd.leaf_raddr  = req.slot;
        cmd.inner_raddr = node_idx ^ bit_up;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.leaf_we           = 1'b1;
                cmd.leaf_waddr        = clr_reg;
                cmd.inner_we          = ~&clr_reg;
                cmd.inner_waddr       = clr_reg;
                cmd.inner_wdata.value = '0;
                // Lowest slot of the node's range: its trailing ones cleared.
                cmd.inner_wdata.slot  = clr_reg & (clr_reg + 1'b1);
            end
            ST_IDLE:
            begin
                cmd.leaf_we = 1'b0;
            end
            ST_ADD:
            begin
                cmd.leaf_we    = 1'b1;
                cmd.leaf_waddr = slot_reg;
                cmd.leaf_wdata = sum;
                cmd.leaf_raddr = idx_reg ^ bit_reg;
            end
            ST_CMP:
            begin
                cmd.inner_we    = 1'b1;
                cmd.inner_waddr = node_idx;
                cmd.inner_wdata = win;
            end
            default:
            begin
                cmd.leaf_we = 1'b0;
            end
        endcase
    end

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        done_next  = 1'b0;
        rsp_next   = rsp_reg;
        slot_next  = slot_reg;
        delta_next = delta_reg;
        idx_next   = idx_reg;
        bit_next   = bit_reg;
        half_next  = half_reg;
        cur_next   = cur_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_next = clr_reg + 1'b1;
                if (&clr_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    slot_next  = req.slot;
                    delta_next = req.delta;
                    idx_next   = req.slot;
                    bit_next   = patm_pkg::slot_t'(1);
                    half_next  = '0;
                    state_next = ST_ADD;
                end
            end
            ST_ADD:
            begin
                cur_next.value = sum;
                cur_next.slot  = slot_reg;
                state_next     = ST_CMP;
            end
            ST_CMP:
            begin
                cur_next  = win;
                idx_next  = node_idx;
                half_next = bit_reg;
                bit_next  = bit_up;
                if (bit_reg[patm_pkg::SLOT_W-1])
                begin
                    // Root rebuilt: report it.
                    done_next           = 1'b1;
                    rsp_next.best_value = win.value;
                    rsp_next.best_slot  = win.slot;
                    state_next          = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            done_reg  <= done_next;
        end
    end

    // Payload and path registers.
    always_ff @(posedge clk)
    begin
        rsp_reg   <= rsp_next;
        slot_reg  <= slot_next;
        delta_reg <= delta_next;
        idx_reg   <= idx_next;
        bit_reg   <= bit_next;
        half_reg  <= half_next;
        cur_reg   <= cur_next;
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

`default_nettype wire

// ----- rtl/core/point_add_argmax_tree.sv -----
`default_nettype none

// Channel   Ports                   Direction  Handshake
// request   start, busy, req        in         taken when start is high and busy low
// result    done, rsp               out        done high for one cycle, always taken
//
// A request is one leaf read, one add and write, then ten
// compare-and-write steps through the shared select unit, one tree level each.
// The result shows in the cycle after the root is rebuilt, as busy falls.
// After reset a clearing pass zeroes all 1024 leaves and the inner nodes; busy stays high meanwhile.
// The receiver cannot stall; results never wait.
module point_add_argmax_tree (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    input  wire patm_pkg::req_t req,
    output logic                busy,
    output logic                done,
    output patm_pkg::rsp_t      rsp
);

    patm_pkg::mem_cmd_t cmd;
    patm_pkg::val_t     leaf_rdata;
    patm_pkg::entry_t   inner_rdata;
    patm_pkg::entry_t   cur;
    patm_pkg::entry_t   sib;
    patm_pkg::entry_t   win;
    logic               cur_is_right;

    // Sequencer.
    patm_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .req          (req),
        .busy         (busy),
        .done         (done),
        .rsp          (rsp),
        .leaf_rdata   (leaf_rdata),
        .inner_rdata  (inner_rdata),
        .win          (win),
        .cur          (cur),
        .sib          (sib),
        .cur_is_right (cur_is_right),
        .cmd          (cmd)
    );

    // Shared compare and select unit.
    patm_pick u_pick (
        .cur          (cur),
        .sib          (sib),
        .cur_is_right (cur_is_right),
        .win          (win)
    );

    // Tree storage.
    patm_mem u_mem (
        .clk          (clk),
        .cmd          (cmd),
        .leaf_rdata   (leaf_rdata),
        .inner_rdata  (inner_rdata)
    );

endmodule

`default_nettype wire

// ----- tb/sv/tb_point_add_argmax_tree.sv -----
`timescale 1ns / 100ps

module tb_point_add_argmax_tree;

    localparam int NUM_RANDOM = 1425;
    localparam int SETTLE_CYCLES = 30;
    localparam int MAX_GAP = 15;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    patm_pkg::req_t req = '0;
    logic busy;
    logic done;
    patm_pkg::rsp_t rsp;

    // Requests waiting to be issued and best entries waiting to come back.
    patm_pkg::req_t pending_req[$];
    patm_pkg::rsp_t pending_best[$];

    // Our own copy of the counter table.
    patm_pkg::val_t tally[patm_pkg::LEAVES];

    int mismatches = 0;
    int gap_left = 0;
    int accepted = 0;
    bit quiet = 1'b0;

    point_add_argmax_tree dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .req   (req),
        .busy  (busy),
        .done  (done),
        .rsp   (rsp)
    );

    always #5 clk = ~clk;

    // Apply one request to the table and return the global maximum, lowest slot on ties.
    function automatic patm_pkg::rsp_t add_and_find_best(patm_pkg::req_t r);
        patm_pkg::rsp_t best;
        tally[r.slot] = tally[r.slot] + r.delta;
        best.best_value = tally[0];
        best.best_slot = '0;
        for (int i = 1; i < patm_pkg::LEAVES; i++)
        begin
            if (tally[i] > best.best_value)
            begin
                best.best_value = tally[i];
                best.best_slot = patm_pkg::slot_t'(i);
            end
        end
        return best;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("[%0t] %s: got %0d, wanted %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    task automatic queue_req(patm_pkg::slot_t s, patm_pkg::val_t d);
        patm_pkg::req_t r;
        r.slot = s;
        r.delta = d;
        pending_req.push_back(r);
    endtask

    // Driver: issues the oldest pending request, with a random gap after each one outside back-to-back spells.
    always @(posedge clk)
    begin : driver
        logic taken;
        taken = start && !busy;
        if (taken)
        begin
            pending_best.push_back(add_and_find_best(req));
            void'(pending_req.pop_front());
            accepted++;
            // Every so often switch between back-to-back issue and random gaps.
            if (accepted % 128 == 0)
                quiet = ($urandom_range(0, 2) == 0);
            gap_left = quiet ? 0 : $urandom_range(0, MAX_GAP);
        end
        if (taken || !start)
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                start <= 1'b0;
            end
            else if (pending_req.size() > 0)
            begin
                start <= 1'b1;
                req <= pending_req[0];
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: every result is checked against the oldest prediction.
    always @(posedge clk)
    begin : monitor
        patm_pkg::rsp_t want;
        if (rst_n && done)
        begin
            if (pending_best.size() == 0)
            begin
                report_mismatch("result with no request outstanding", rsp.best_value, 0);
            end
            else
            begin
                want = pending_best.pop_front();
                if (rsp.best_value !== want.best_value)
                    report_mismatch("best_value", rsp.best_value, want.best_value);
                if (rsp.best_slot !== want.best_slot)
                    report_mismatch("best_slot", rsp.best_slot, want.best_slot);
            end
        end
    end

    // Stimulus, reset and the end of the run.
    initial
    begin
        patm_pkg::slot_t hot_slots[8];
        patm_pkg::slot_t s;
        patm_pkg::val_t d;
        int pick;

        for (int i = 0; i < patm_pkg::LEAVES; i++)
            tally[i] = '0;

        // Directed part: empty-table query, ties, wrap-around and the field extremes.
        queue_req(10'd0, 32'sd0);
        queue_req(10'd1023, 32'sd0);
        queue_req(10'd1023, 32'sd1);
        queue_req(10'd0, 32'sd1);
        queue_req(10'd1023, 32'sd2147483646);
        queue_req(10'd1023, 32'sd1);
        queue_req(10'd512, 32'sd1);
        queue_req(10'd0, -32'sd1);
        queue_req(10'd511, 32'sd1);
        queue_req(10'd0, -32'sd1);
        queue_req(10'd511, -32'sd1);
        queue_req(10'd512, -32'sd1);
        queue_req(10'd5, patm_pkg::val_t'(32'h8000_0000));
        queue_req(10'd700, patm_pkg::val_t'(32'h7fff_ffff));
        queue_req(10'd699, patm_pkg::val_t'(32'h7fff_ffff));
        queue_req(10'd700, patm_pkg::val_t'(32'h8000_0001));
        queue_req(10'd699, patm_pkg::val_t'(32'h8000_0001));
        queue_req(10'd1023, 32'sd0);
        queue_req(10'd341, patm_pkg::val_t'(32'hffff_ffff));
        queue_req(10'd682, patm_pkg::val_t'(32'h5555_5555));
        queue_req(10'd682, patm_pkg::val_t'(32'haaaa_aaab));
        queue_req(10'd0, 32'sd0);

        // Random part: half the requests go to a small set of contested slots, the rest anywhere in the table.
        for (int n = 0; n < NUM_RANDOM; n++)
        begin
            if (n % 200 == 0)
            begin
                for (int k = 0; k < 8; k++)
                    hot_slots[k] = patm_pkg::slot_t'($urandom);
            end
            s = ($urandom_range(0, 1) == 0) ? hot_slots[$urandom_range(0, 7)]
                                            : patm_pkg::slot_t'($urandom);
            pick = $urandom_range(0, 9);
            if (pick < 4)
                d = patm_pkg::val_t'(int'($urandom_range(0, 16)) - 8);
            else if (pick < 6)
                d = '0;
            else if (pick < 8)
                d = patm_pkg::val_t'($urandom);
            else if (pick == 8)
            begin
                case ($urandom_range(0, 3))
                    0: d = patm_pkg::val_t'(32'h7fff_ffff);
                    1: d = patm_pkg::val_t'(32'h8000_0000);
                    2: d = patm_pkg::val_t'(32'hffff_ffff);
                    default: d = 32'sd1;
                endcase
            end
            else
                d = patm_pkg::val_t'($urandom_range(0, 32'h7fff_ffff));
            queue_req(s, d);
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_req.size() != 0 || pending_best.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run, clearing pass included.
    initial
    begin
        #4ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/patm_pkg.sv
rtl/core/patm_mem.sv
rtl/core/patm_pick.sv
rtl/core/patm_ctrl.sv
rtl/core/point_add_argmax_tree.sv
tb/sv/tb_point_add_argmax_tree.sv
